[rtl/multi_queue_linked_manager_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linked queue manager
// Short forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_LINKED_MANAGER_ASSERT_SVH
`define MULTI_QUEUE_LINKED_MANAGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MQLM_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MQLM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mqlm_pkg.sv]
// ----------------------------------------------------------------------------
// mqlm_pkg
// Types, codes and default sizes shared by the linked queue manager files.
// ----------------------------------------------------------------------------
package mqlm_pkg;

	localparam int NUM_QUEUES_DEF = 16;
	localparam int POOL_NODES_DEF = 256;
	localparam int KEY_BITS_DEF   = 32;

	// Fixed port widths.
	localparam int KEY_W    = 32;
	localparam int QIDX_W   = 4;
	localparam int STATUS_W = 2;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_POP,
		ST_HOLD
	} mqlm_state_t;

endpackage

[rtl/multi_queue_linked_manager.sv]
// ----------------------------------------------------------------------------
// multi_queue_linked_manager
// Several FIFO queues kept as linked lists in one shared node store.
// ----------------------------------------------------------------------------
// Usage: a request beat (req_type, queue_index, key) on the in_valid/in_ready
// channel either enqueues key onto the addressed queue or dequeues the oldest
// key from it. Each request yields exactly one result beat (out_key, status)
// on the out_valid/out_ready channel: status 0 done, 1 queue empty (or index
// out of range) on dequeue, 2 pool full (or index out of range) on enqueue;
// out_key is zero unless a dequeue succeeds. Nodes come from never-used
// slots first, then from a free list of nodes returned by dequeues.
// Timing: an enqueue or a rejected request is settled in the look state;
// a successful dequeue passes through the pop state as well, because the
// head pointer must come out of the registered pointer memory before the
// node itself can be read. One request is in flight at a time, so in_ready
// is high only while the sequencer is idle.
// Reset: every queue and the free list are empty and all slots are unused.
// No clearing pass runs; the block is ready as soon as reset is released.
// Stall: a result waits in the output register; if it is still unaccepted
// when the next one is ready, the sequencer holds until out_ready is seen.
// ----------------------------------------------------------------------------
module multi_queue_linked_manager #(
	parameter int NUM_QUEUES = mqlm_pkg::NUM_QUEUES_DEF,
	parameter int POOL_NODES = mqlm_pkg::POOL_NODES_DEF,
	parameter int KEY_BITS   = mqlm_pkg::KEY_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 req_type,
	input  logic [mqlm_pkg::QIDX_W-1:0]          queue_index,
	input  logic signed [mqlm_pkg::KEY_W-1:0]    key,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mqlm_pkg::KEY_W-1:0]    out_key,
	output logic [mqlm_pkg::STATUS_W-1:0]        status
);

	localparam int PTR_W  = $clog2(POOL_NODES);
	localparam int CNT_W  = $clog2(POOL_NODES + 1);
	localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int QCMP_W = mqlm_pkg::QIDX_W + 3;
	localparam int EXT_W  = (KEY_BITS > mqlm_pkg::KEY_W) ? KEY_BITS : mqlm_pkg::KEY_W;

	// Storage.
	logic [KEY_BITS-1:0] node_key_q  [POOL_NODES];
	logic [PTR_W-1:0]    node_next_q [POOL_NODES];
	logic [PTR_W-1:0]    head_q      [NUM_QUEUES];
	logic [PTR_W-1:0]    tail_q      [NUM_QUEUES];

	// Registered read data.
	logic [KEY_BITS-1:0] key_rd_q;
	logic [PTR_W-1:0]    next_rd_q;
	logic [PTR_W-1:0]    head_rd_q;
	logic [PTR_W-1:0]    tail_rd_q;

	// Control state.
	mqlm_pkg::mqlm_state_t state_q, state_d;
	logic [NUM_QUEUES-1:0] queue_busy_q;
	logic [CNT_W-1:0]      fresh_q;
	logic [CNT_W-1:0]      recycle_cnt_q;
	logic [PTR_W-1:0]      recycle_head_q;
	logic                  recycle_busy_q;
	logic                  out_valid_q;

	// Latched request and pending result.
	logic                                 req_q;
	logic [mqlm_pkg::QIDX_W-1:0]          qidx_q;
	logic signed [mqlm_pkg::KEY_W-1:0]    key_q;
	logic signed [mqlm_pkg::KEY_W-1:0]    res_key_q;
	logic [mqlm_pkg::STATUS_W-1:0]        res_status_q;
	logic signed [mqlm_pkg::KEY_W-1:0]    out_key_q;
	logic [mqlm_pkg::STATUS_W-1:0]        status_q;

	// Combinational request decode.
	logic              in_fire;
	logic              out_free;
	logic [QW-1:0]     qi;
	logic [QW-1:0]     qa;
	logic              q_ok;
	logic              have_fresh;
	logic              enq_ok;
	logic              deq_ok;
	logic [PTR_W-1:0]  slot;
	logic [EXT_W-1:0]  key_ext;
	logic [EXT_W-1:0]  out_ext;

	// Sequencer outputs.
	logic                                 fin;
	logic                                 out_load;
	logic signed [mqlm_pkg::KEY_W-1:0]    res_key;
	logic [mqlm_pkg::STATUS_W-1:0]        res_status;
	logic                                 nk_we;
	logic                                 nn_we;
	logic [PTR_W-1:0]                     nn_waddr;
	logic [PTR_W-1:0]                     nn_wdata;
	logic                                 nn_re;
	logic [PTR_W-1:0]                     nn_raddr;
	logic                                 nk_re;
	logic                                 hd_we;
	logic [PTR_W-1:0]                     hd_wdata;
	logic                                 tl_we;
	logic                                 busy_set;
	logic                                 busy_clr;
	logic                                 pop_free;
	logic                                 push_free;
	logic                                 take_fresh;

	assign in_ready   = (state_q == mqlm_pkg::ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign qi         = QW'(qidx_q);
	assign qa         = QW'(queue_index);
	assign q_ok       = QCMP_W'(qidx_q) < QCMP_W'(NUM_QUEUES);
	assign have_fresh = fresh_q < CNT_W'(POOL_NODES);
	assign enq_ok     = q_ok && (have_fresh || recycle_busy_q);
	assign deq_ok     = q_ok && queue_busy_q[qi];
	assign slot       = have_fresh ? fresh_q[PTR_W-1:0] : recycle_head_q;
	// Sign extension from the port width, then from the stored width on the way out.
	assign key_ext    = EXT_W'(key_q);
	assign out_ext    = EXT_W'($signed(key_rd_q));

	assign out_valid  = out_valid_q;
	assign out_key    = out_key_q;
	assign status     = status_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mqlm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = mqlm_pkg::ST_LOOK;
				end
			end
			mqlm_pkg::ST_LOOK: begin
				if (req_q == mqlm_pkg::REQ_DEQ && deq_ok) begin
					state_d = mqlm_pkg::ST_POP;
				end else if (out_free) begin
					state_d = mqlm_pkg::ST_IDLE;
				end else begin
					state_d = mqlm_pkg::ST_HOLD;
				end
			end
			mqlm_pkg::ST_POP, mqlm_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = mqlm_pkg::ST_IDLE;
				end else begin
					state_d = mqlm_pkg::ST_HOLD;
				end
			end
			default: state_d = mqlm_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		fin        = 1'b0;
		out_load   = 1'b0;
		res_key    = '0;
		res_status = mqlm_pkg::STAT_DONE;
		nk_we      = 1'b0;
		nn_we      = 1'b0;
		nn_waddr   = tail_rd_q;
		nn_wdata   = slot;
		nn_re      = 1'b0;
		nn_raddr   = recycle_head_q;
		nk_re      = 1'b0;
		hd_we      = 1'b0;
		hd_wdata   = slot;
		tl_we      = 1'b0;
		busy_set   = 1'b0;
		busy_clr   = 1'b0;
		pop_free   = 1'b0;
		push_free  = 1'b0;
		take_fresh = 1'b0;
		unique case (state_q)
			mqlm_pkg::ST_IDLE: begin
				// Fetch the link of the free-list top in case this is an enqueue.
				nn_re = in_fire;
			end
			mqlm_pkg::ST_LOOK: begin
				if (req_q == mqlm_pkg::REQ_ENQ) begin
					fin = 1'b1;
					if (enq_ok) begin
						nk_we      = 1'b1;
						tl_we      = 1'b1;
						busy_set   = 1'b1;
						take_fresh = have_fresh;
						pop_free   = !have_fresh;
						if (queue_busy_q[qi]) begin
							nn_we = 1'b1;
						end else begin
							hd_we = 1'b1;
						end
					end else begin
						res_status = mqlm_pkg::STAT_FULL;
					end
				end else if (deq_ok) begin
					nn_re    = 1'b1;
					nn_raddr = head_rd_q;
					nk_re    = 1'b1;
				end else begin
					fin        = 1'b1;
					res_status = mqlm_pkg::STAT_EMPTY;
				end
				out_load = fin && out_free;
			end
			mqlm_pkg::ST_POP: begin
				fin       = 1'b1;
				res_key   = out_ext[mqlm_pkg::KEY_W-1:0];
				push_free = 1'b1;
				nn_we     = 1'b1;
				nn_waddr  = head_rd_q;
				nn_wdata  = recycle_head_q;
				hd_wdata  = next_rd_q;
				if (head_rd_q == tail_rd_q) begin
					busy_clr = 1'b1;
				end else begin
					hd_we = 1'b1;
				end
				out_load = out_free;
			end
			mqlm_pkg::ST_HOLD: begin
				res_key    = res_key_q;
				res_status = res_status_q;
				out_load   = out_free;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mqlm_pkg::ST_IDLE;
			queue_busy_q   <= '0;
			fresh_q        <= '0;
			recycle_cnt_q  <= '0;
			recycle_head_q <= '0;
			recycle_busy_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (busy_set) begin
				queue_busy_q[qi] <= 1'b1;
			end else if (busy_clr) begin
				queue_busy_q[qi] <= 1'b0;
			end
			if (take_fresh) begin
				fresh_q <= fresh_q + CNT_W'(1);
			end
			if (pop_free) begin
				recycle_cnt_q <= recycle_cnt_q - CNT_W'(1);
				if (recycle_cnt_q == CNT_W'(1)) begin
					recycle_busy_q <= 1'b0;
				end else begin
					recycle_head_q <= next_rd_q;
				end
			end else if (push_free) begin
				recycle_cnt_q  <= recycle_cnt_q + CNT_W'(1);
				recycle_head_q <= head_rd_q;
				recycle_busy_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, result and output payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q  <= req_type;
			qidx_q <= queue_index;
			key_q  <= key;
		end
		if (fin) begin
			res_key_q    <= res_key;
			res_status_q <= res_status;
		end
		if (out_load) begin
			out_key_q <= res_key;
			status_q  <= res_status;
		end
	end

	// Node store.
	always_ff @(posedge clk) begin
		if (nk_we) begin
			node_key_q[slot] <= key_ext[KEY_BITS-1:0];
		end
		if (nk_re) begin
			key_rd_q <= node_key_q[head_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (nn_we) begin
			node_next_q[nn_waddr] <= nn_wdata;
		end
		if (nn_re) begin
			next_rd_q <= node_next_q[nn_raddr];
		end
	end

	// Queue head and tail pointers.
	always_ff @(posedge clk) begin
		if (hd_we) begin
			head_q[qi] <= hd_wdata;
		end
		if (in_fire) begin
			head_rd_q <= head_q[qa];
		end
	end

	always_ff @(posedge clk) begin
		if (tl_we) begin
			tail_q[qi] <= slot;
		end
		if (in_fire) begin
			tail_rd_q <= tail_q[qa];
		end
	end

endmodule

[rtl/mqlm_checker.sv]
// ----------------------------------------------------------------------------
// mqlm_checker
// Port-level checks for the linked queue manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_queue_linked_manager_assert.svh"

module mqlm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 req_type,
	input logic [mqlm_pkg::QIDX_W-1:0]          queue_index,
	input logic signed [mqlm_pkg::KEY_W-1:0]    key,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [mqlm_pkg::KEY_W-1:0]    out_key,
	input logic [mqlm_pkg::STATUS_W-1:0]        status
);

	logic                                          in_fire;
	logic                                          in_wait;
	logic                                          out_stall;
	logic                                          out_fail;
	logic [mqlm_pkg::QIDX_W+mqlm_pkg::KEY_W:0]     in_beat;
	logic [mqlm_pkg::KEY_W+mqlm_pkg::STATUS_W-1:0] out_beat;

	assign in_fire   = in_valid && in_ready;
	assign in_wait   = in_valid && !in_ready;
	assign out_stall = out_valid && !out_ready;
	assign out_fail  = out_valid && (status != mqlm_pkg::STAT_DONE);
	assign in_beat   = {req_type, queue_index, key};
	assign out_beat  = {out_key, status};

	// A result beat that is not accepted must stay put.
	`MQLM_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat), "result beat changed")

	// A request that fails returns no key.
	`MQLM_ASSERT_SAME(a_key_zero, out_fail, out_key == '0, "non-zero key with a failure status")

	// The block handles one request at a time.
	`MQLM_ASSERT_NEXT(a_one_at_a_time, in_fire, !in_ready, "request accepted while busy")

	// A request beat that is waiting must stay put.
	`MQLM_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(in_beat), "request beat changed")

endmodule

bind multi_queue_linked_manager mqlm_checker u_mqlm_checker (.*);
